[design/rhe_pkg.sv]
// Shared types and constants for the range histogram engine.
// No dependencies; imported by every module of the block but rhe_ram.
`default_nettype none
package rhe_pkg;

  // Number of counters, underflow and overflow bins included (3..64)
  localparam int unsigned NUM_BINS  = 64;
  localparam int unsigned IDX_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned BIN_IDX_W = 6;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned PROD_W    = SCALE_W + SAMPLE_W;
  localparam int unsigned FRAC_W    = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic [SCALE_W-1:0]         bin_scale;
  } rhe_cfg_t;

  // One classified sample travelling from front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             clr;
    logic             last;
  } rhe_item_t;

  // One reported bin
  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [CNT_W-1:0]     bin_count;
    logic                 last_bin;
  } rhe_bin_t;

endpackage
`default_nettype wire

[design/rhe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rhe_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[design/rhe_front.sv]
// Front end: accepts samples and maps each to a bin in two stages.
// Depends on rhe_pkg.
`default_nettype none
module rhe_front import rhe_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rhe_cfg_t                   cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       clear_first,
  input  wire logic                       last,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output rhe_item_t                       push_item
);

  // stage 0: range compare and offset
  logic                s0_v_r, s0_v_nxt;
  logic                s0_under_r, s0_over_r, s0_clr_r, s0_last_r;
  logic [SAMPLE_W-1:0] s0_off_r;
  // stage 1: scaled offset
  logic                s1_v_r, s1_v_nxt;
  logic                s1_under_r, s1_over_r, s1_clr_r, s1_last_r;
  logic [PROD_W-1:0]   s1_prod_r;

  logic                s0_free, s1_free, s1_load, in_fire;
  logic [SCALE_W-1:0]  hi;

  assign s1_free  = !s1_v_r || push_ready;
  assign s0_free  = !s0_v_r || s1_free;
  assign s1_load  = s0_v_r && s1_free;
  assign in_ready = s0_free;
  assign in_fire  = in_valid && s0_free;

  always_comb begin
    s0_v_nxt = s0_v_r;
    if (in_fire) begin
      s0_v_nxt = 1'b1;
    end else if (s1_load) begin
      s0_v_nxt = 1'b0;
    end
    s1_v_nxt = s1_v_r;
    if (s1_load) begin
      s1_v_nxt = 1'b1;
    end else if (push_ready) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_under_r <= sample < cfg.min_value;
      s0_over_r  <= sample >= cfg.max_value;
      s0_off_r   <= sample - cfg.min_value;
      s0_clr_r   <= clear_first;
      s0_last_r  <= last;
    end
    if (s1_load) begin
      s1_under_r <= s0_under_r;
      s1_over_r  <= s0_over_r;
      s1_prod_r  <= {{SAMPLE_W{1'b0}}, cfg.bin_scale} * {{SCALE_W{1'b0}}, s0_off_r};
      s1_clr_r   <= s0_clr_r;
      s1_last_r  <= s0_last_r;
    end
  end

  // Truncate the Q32.16 product, step past the underflow bin, clamp
  assign hi = s1_prod_r[PROD_W-1:FRAC_W];

  always_comb begin
    push_item.clr  = s1_clr_r;
    push_item.last = s1_last_r;
    if (s1_under_r) begin
      push_item.idx = '0;
    end else if (s1_over_r) begin
      push_item.idx = IDX_W'(NUM_BINS - 1);
    end else if (hi > SCALE_W'(NUM_BINS - 3)) begin
      push_item.idx = IDX_W'(NUM_BINS - 2);
    end else begin
      push_item.idx = hi[IDX_W-1:0] + IDX_W'(1);
    end
  end

  assign push_valid = s1_v_r;

endmodule
`default_nettype wire

[design/rhe_queue.sv]
// Two-entry queue of classified samples between front and back.
// Depends on rhe_pkg.
`default_nettype none
module rhe_queue import rhe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire rhe_item_t push_item,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output rhe_item_t      pop_item
);

  rhe_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[design/rhe_back.sv]
// Back end: read-modify-write of the bin counters and the bin dump.
// Depends on rhe_pkg and rhe_ram.
`default_nettype none
module rhe_back import rhe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      pop_valid,
  output logic           pop_ready,
  input  wire rhe_item_t pop_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rhe_bin_t       out_bin
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RMW  = 5'b00010,
    ST_DRD  = 5'b00100,
    ST_DCAP = 5'b01000,
    ST_DOUT = 5'b10000
  } rhe_bst_t;

  rhe_bst_t            st_r, st_nxt;
  logic [NUM_BINS-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]    cur_idx_r, cur_idx_nxt;
  logic                cur_last_r, cur_last_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic                out_v_r, out_v_nxt;
  rhe_bin_t            out_r, out_nxt;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [CNT_W-1:0]    ram_rdata, old_cnt, new_cnt;

  rhe_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_idx_r),
    .wdata(new_cnt),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A bin not written since reset or the last clear reads as zero
  assign old_cnt   = valid_r[cur_idx_r] ? ram_rdata : '0;
  assign new_cnt   = (&old_cnt) ? old_cnt : old_cnt + CNT_W'(1);
  assign pop_ready = st_r == ST_IDLE;
  assign out_valid = out_v_r;
  assign out_bin   = out_r;

  always_comb begin
    st_nxt       = st_r;
    valid_nxt    = valid_r;
    cur_idx_nxt  = cur_idx_r;
    cur_last_nxt = cur_last_r;
    k_nxt        = k_r;
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = k_r;
    unique case (st_r)
      ST_IDLE: begin
        if (pop_valid) begin
          cur_idx_nxt  = pop_item.idx;
          cur_last_nxt = pop_item.last;
          if (pop_item.clr) begin
            valid_nxt = '0;
          end
          ram_re    = 1'b1;
          ram_raddr = pop_item.idx;
          st_nxt    = ST_RMW;
        end
      end
      ST_RMW: begin
        ram_we               = 1'b1;
        valid_nxt[cur_idx_r] = 1'b1;
        if (cur_last_r) begin
          k_nxt  = '0;
          st_nxt = ST_DRD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_DRD: begin
        ram_re = 1'b1;
        st_nxt = ST_DCAP;
      end
      ST_DCAP: begin
        out_v_nxt         = 1'b1;
        out_nxt.bin_index = BIN_IDX_W'(k_r);
        out_nxt.bin_count = valid_r[k_r] ? ram_rdata : '0;
        out_nxt.last_bin  = k_r == IDX_W'(NUM_BINS - 1);
        st_nxt            = ST_DOUT;
      end
      ST_DOUT: begin
        if (out_ready) begin
          out_v_nxt = 1'b0;
          if (k_r == IDX_W'(NUM_BINS - 1)) begin
            st_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = k_r + IDX_W'(1);
            st_nxt    = ST_DCAP;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      valid_r <= '0;
      out_v_r <= 1'b0;
      k_r     <= '0;
    end else begin
      st_r    <= st_nxt;
      valid_r <= valid_nxt;
      out_v_r <= out_v_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r  <= cur_idx_nxt;
    cur_last_r <= cur_last_nxt;
    out_r      <= out_nxt;
  end

endmodule
`default_nettype wire

[design/range_histogram_engine_top.sv]
// Top level of the range histogram engine: configuration registers and wiring.
// Depends on rhe_pkg, rhe_front, rhe_queue, rhe_back (and rhe_ram below it).
//
// Usage
//   in_*  : one sample per request. in_tdata[15:0] = sample (signed),
//           in_tuser = clear_first, in_tlast = last of the vector.
//   out_* : one bin per request. out_tdata[5:0] = bin_index,
//           out_tdata[37:6] = bin_count, out_tdata[39:38] = 0,
//           out_tlast = last_bin (set on bin NUM_BINS-1).
//   cfg_* : APB-style register port, pready tied high. Registers at byte
//           addresses 0 (min_value), 4 (max_value), 8 (bin_scale, Q16.16).
//           Write only while the block is idle.
// Timing
//   The front accepts a sample per cycle, unless held by a full queue, into a
//   two-stage classify pipe (compare, then Q16.16 multiply) and a two-entry
//   queue. The back updates one counter at a time, reading it and then
//   writing it back to the single counter RAM, and takes no new sample until
//   that write is done. A request marked last starts the dump after its own
//   counter is written; each bin is read, captured and offered on out_*.
//   During the dump the front keeps taking samples until the queue and the
//   classify pipe fill. A stalled output holds its bin and the dump waits.
// Reset: rst_n (synchronous) empties the pipeline, clears every counter at once
//   through per-bin valid flags and loads the register defaults.
`default_nettype none
module range_histogram_engine_top import rhe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // sample input: tdata = {sample[15:0]}, tuser = {clear_first}
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  // bin output: tdata = {bin_index[5:0], bin_count[37:6], zero pad[39:38]}
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [1:0] REG_MIN   = 2'd0;
  localparam logic [1:0] REG_MAX   = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  logic signed [SAMPLE_W-1:0] min_value_r, max_value_r;
  logic [SCALE_W-1:0]         bin_scale_r;
  logic                       cfg_wr;
  rhe_cfg_t                   cfg;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  rhe_item_t push_item, pop_item;
  rhe_bin_t  out_bin;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes; index from the word address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r <= 16'sd0;
      max_value_r <= 16'sd32767;
      bin_scale_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MIN:   min_value_r <= cfg_pwdata[SAMPLE_W-1:0];
        REG_MAX:   max_value_r <= cfg_pwdata[SAMPLE_W-1:0];
        REG_SCALE: bin_scale_r <= cfg_pwdata;
        default: begin
          // unmapped: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MIN:   cfg_prdata = 32'(min_value_r);
      REG_MAX:   cfg_prdata = 32'(max_value_r);
      REG_SCALE: cfg_prdata = bin_scale_r;
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.min_value = min_value_r;
  assign cfg.max_value = max_value_r;
  assign cfg.bin_scale = bin_scale_r;

  rhe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .sample     (in_tdata),
    .clear_first(in_tuser),
    .last       (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rhe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  rhe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_item (pop_item),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_bin  (out_bin)
  );

  assign out_tdata = {2'b00, out_bin.bin_count, out_bin.bin_index};
  assign out_tlast = out_bin.last_bin;

`ifndef SYNTH
  // last_bin marks exactly the final bin of the dump
  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[5:0] == 6'(NUM_BINS - 1))))
    else $error("last_bin does not match final bin index");

  // after a non-final bin is taken, the bin with the next index follows
  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |-> ##2
      (out_tvalid && (out_tdata[5:0] == $past(out_tdata[5:0], 2) + 6'd1)))
    else $error("bin dump out of order");

  // the dump always starts at bin zero
  a_dump_start: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_tvalid) && $past(out_tlast)) |-> (out_tdata[5:0] == 6'd0))
    else $error("dump does not start at bin zero");
`endif

endmodule
`default_nettype wire
